[design/sps_pkg.sv]
package sps_pkg;

  // Field widths
  localparam int TYPE_W    = 2;
  localparam int SERVO_W   = 3;
  localparam int ANG_W     = 11;
  localparam int CANG_W    = 8;
  localparam int CHAN_W    = 2;
  localparam int DUTY_W    = 15;
  localparam int PULSE_W   = 15;
  localparam int RET_W     = 16;
  localparam int IDLE_W    = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // Angle range and duty scale
  localparam logic [CANG_W-1:0] ANGLE_MAX = 8'd180;
  localparam logic [DUTY_W-1:0] FULL_DUTY = 15'd16384;

  // Divide by 180 through a reciprocal: floor(2^30 / 180)
  localparam logic [22:0] DIV180_M = 23'd5965232;
  localparam int          DIV180_K = 30;

  // 16384 / 20000 reduces to 512 / 625; floor(2^33 / 625)
  localparam int          PERIOD_SHIFT = 9;
  localparam logic [9:0]  PERIOD_DIV   = 10'd625;
  localparam logic [23:0] DIV625_M     = 24'd13743895;
  localparam int          DIV625_K     = 33;

  // Register reset values
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 15'd500;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 15'd2500;
  localparam logic [RET_W-1:0]   RETURN_RST    = 16'd300;
  localparam logic [IDLE_W-1:0]  TIMEOUT_RST   = 17'd60000;
  localparam logic [CANG_W-1:0]  NEUTRAL_RST   = 8'd90;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PULSE    = 2'd0,
    CFG_MAX_PULSE    = 2'd1,
    CFG_RETURN       = 2'd2,
    CFG_IDLE_TIMEOUT = 2'd3
  } cfg_reg_e;

  typedef enum logic [TYPE_W-1:0] {
    REQ_DIRECT = 2'd0,
    REQ_QUEUE  = 2'd1,
    REQ_TICK   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QTAKE,
    ST_DUTY,
    ST_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    req_e               kind;
    logic [SERVO_W-1:0] servo;
    logic [CANG_W-1:0]  ang;
    logic [CANG_W-1:0]  neu;
  } item_t;

  typedef struct packed {
    logic [SERVO_W-1:0] servo;
    logic [CANG_W-1:0]  target;
    logic [CANG_W-1:0]  neutral;
  } qent_t;

  localparam int QENT_W = SERVO_W + 2 * CANG_W;

  typedef struct packed {
    logic [PULSE_W-1:0] min_pulse;
    logic [PULSE_W-1:0] max_pulse;
    logic [RET_W-1:0]   return_ms;
    logic [IDLE_W-1:0]  idle_timeout;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [DUTY_W-1:0] duty;
    logic              dropped;
    logic              last;
  } res_t;

endpackage

[design/servo_pulse_sequencer.sv]
// Servo pulse sequencer: maps servo commands to 15-bit duty counts (full scale 16384) of a 20 ms period.
// Input stream: s_axis_tuser carries the request kind (direct set, queued quick
// action, millisecond tick); s_axis_tdata carries servo number and angles.
// Output stream: one item per channel update, channel and duty in tdata, the
// queue-full drop flag in tuser, tlast on the final result of a request.
// Configuration: write cfg_we_i with a register index and data; only while idle.
// A two-entry request queue sits in front, so a request is taken in the cycle it
// arrives while the queue has room; requests are then carried out one at a time.
// Flow: a queue write, a plain tick or an ignored request leaves the back end
// idle; each duty result passes from request pickup through ST_DUTY, the
// five-stage duty pipeline and ST_WAIT to the output register; a power-down
// emits one result per cycle per channel while the receiver is ready; a dropped quick action one.
// Taking a quick action from the command queue adds the ST_QTAKE state for its RAM read.
// Reset clears the queues, the hold and idle counters, and restores the
// register defaults; the command store itself is not cleared.
// When the receiver stalls, the finished result waits in the output register,
// the back end holds, and the front keeps taking requests until its queue is full.
module servo_pulse_sequencer #(
  parameter int NUM_SERVOS  = 4,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // servo_index [2:0], angle [13:3], return_angle [24:14]
  input  logic [sps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type [1:0]
  input  logic [sps_pkg::TYPE_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // channel [1:0], duty [16:2]
  output logic [sps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // dropped [0]
  output logic [0:0]                     m_axis_tuser,
  output logic                           m_axis_tlast,
  input  logic                           cfg_we_i,
  input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sps_pkg::CFG_W-1:0]      cfg_data_i
);

  sps_pkg::cfg_t  cfg_q, cfg_d;
  sps_pkg::item_t item;
  sps_pkg::res_t  res;
  logic           item_valid, pop, busy;

  // Update the addressed configuration register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sps_pkg::CFG_MIN_PULSE:    cfg_d.min_pulse    = cfg_data_i[sps_pkg::PULSE_W-1:0];
        sps_pkg::CFG_MAX_PULSE:    cfg_d.max_pulse    = cfg_data_i[sps_pkg::PULSE_W-1:0];
        sps_pkg::CFG_RETURN:       cfg_d.return_ms    = cfg_data_i[sps_pkg::RET_W-1:0];
        sps_pkg::CFG_IDLE_TIMEOUT: cfg_d.idle_timeout = cfg_data_i[sps_pkg::IDLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse    <= sps_pkg::MIN_PULSE_RST;
      cfg_q.max_pulse    <= sps_pkg::MAX_PULSE_RST;
      cfg_q.return_ms    <= sps_pkg::RETURN_RST;
      cfg_q.idle_timeout <= sps_pkg::TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_type_i    (s_axis_tuser),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  sps_back #(
    .NUM_SERVOS  (NUM_SERVOS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .busy_o       (busy),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  // Pack the result
  assign m_axis_tdata = {(sps_pkg::OUT_DATA_W - sps_pkg::CHAN_W - sps_pkg::DUTY_W)'(0),
                         res.duty, res.chan};
  assign m_axis_tuser = res.dropped;
  assign m_axis_tlast = res.last;

`ifndef ASSERT_OFF
  // The back end takes a waiting request exactly when it is idle
  a_pickup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop == (item_valid && !busy))
    else $error("request pickup out of step with back end state");

  // A drop report carries no channel or duty and ends its request
  a_drop_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && (m_axis_tdata == '0)))
    else $error("malformed drop report");

  // Duty never exceeds the full period count
  a_duty_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.duty <= sps_pkg::FULL_DUTY))
    else $error("duty above full scale");
`endif

endmodule

[design/sps_ram.sv]
module sps_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/sps_duty.sv]
module sps_duty (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_i,
  input  logic [sps_pkg::CANG_W-1:0]  ang_i,
  input  logic [sps_pkg::PULSE_W-1:0] lo_i,
  input  logic [sps_pkg::PULSE_W-1:0] hi_i,
  output logic                        valid_o,
  output logic [sps_pkg::DUTY_W-1:0]  duty_o
);

  localparam int LAT = 5;

  logic [LAT-1:0] valid_q;

  logic                        fall;
  logic [sps_pkg::PULSE_W-1:0] diff;
  logic [22:0]                 prod1_d, prod1_q, prod2_q;
  logic                        fall1_q, fall2_q;
  logic [45:0]                 mul2;
  logic [15:0]                 est1_q;
  logic [23:0]                 rem1;
  logic [15:0]                 quo1;
  logic [sps_pkg::PULSE_W-1:0] pulse_d, pulse_q;
  logic [23:0]                 num, num_q;
  logic [47:0]                 mul4;
  logic [14:0]                 est2_q;
  logic [23:0]                 rem2;
  logic [15:0]                 quo2;
  logic [sps_pkg::DUTY_W-1:0]  duty_d, duty_q;

  // Stage 1: span of the pulse range times the angle
  assign fall    = (hi_i < lo_i);
  assign diff    = fall ? (lo_i - hi_i) : (hi_i - lo_i);
  assign prod1_d = 23'(ang_i) * 23'(diff);

  // Stage 2: estimate of the quotient by 180
  assign mul2 = 46'(prod1_q) * 46'(sps_pkg::DIV180_M);

  // Stage 3: correct the estimate and offset from the zero-angle pulse
  assign rem1 = 24'(prod2_q) - 24'(est1_q) * 24'(sps_pkg::ANGLE_MAX);
  assign quo1 = est1_q + 16'(rem1 >= 24'(sps_pkg::ANGLE_MAX));
  assign pulse_d = fall2_q ? 15'(17'(lo_i) - 17'(quo1)) : 15'(17'(lo_i) + 17'(quo1));

  // Stage 4: scale the pulse to the period, estimate the quotient by 625
  assign num  = {pulse_q, sps_pkg::PERIOD_SHIFT'(0)};
  assign mul4 = 48'(num) * 48'(sps_pkg::DIV625_M);

  // Stage 5: correct and saturate at full duty
  assign rem2   = num_q - 24'(est2_q) * 24'(sps_pkg::PERIOD_DIV);
  assign quo2   = 16'(est2_q) + 16'(rem2 >= 24'(sps_pkg::PERIOD_DIV));
  assign duty_d = (quo2 > 16'(sps_pkg::FULL_DUTY)) ? sps_pkg::FULL_DUTY : quo2[14:0];

  // Hold the payload of each stage
  always_ff @(posedge clk_i) begin
    prod1_q <= prod1_d;
    fall1_q <= fall;
    est1_q  <= mul2[sps_pkg::DIV180_K +: 16];
    prod2_q <= prod1_q;
    fall2_q <= fall1_q;
    pulse_q <= pulse_d;
    est2_q  <= mul4[sps_pkg::DIV625_K +: 15];
    num_q   <= num;
    duty_q  <= duty_d;
  end

  // Advance the valid marks alongside the payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LAT-2:0], req_i};
    end
  end

  assign valid_o = valid_q[LAT-1];
  assign duty_o  = duty_q;

endmodule

[design/sps_back.sv]
module sps_back #(
  parameter int NUM_SERVOS  = 4,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sps_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  input  sps_pkg::item_t item_i,
  output logic           pop_o,
  output logic           busy_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sps_pkg::res_t  out_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [sps_pkg::CHAN_W-1:0] LAST_CHAN = sps_pkg::CHAN_W'(NUM_SERVOS - 1);

  sps_pkg::state_e state_q, state_d;

  logic [PTR_W-1:0]             head_q, head_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic                         returning_q, returning_d;
  logic [sps_pkg::RET_W-1:0]    countdown_q, countdown_d;
  logic [sps_pkg::SERVO_W-1:0]  pend_servo_q, pend_servo_d;
  logic [sps_pkg::CANG_W-1:0]   pend_neu_q, pend_neu_d;
  logic [sps_pkg::IDLE_W-1:0]   idle_q, idle_d, idle_next;
  logic                         op2_pend_q, op2_pend_d;
  logic                         pdn_q, pdn_d;
  logic [sps_pkg::CHAN_W-1:0]   pdn_cnt_q, pdn_cnt_d;
  logic                         out_valid_q, out_valid_d;

  logic [sps_pkg::CHAN_W-1:0]   op_chan_q, op_chan_d;
  logic [sps_pkg::CANG_W-1:0]   op_ang_q, op_ang_d;
  logic [sps_pkg::CANG_W-1:0]   op2_ang_q, op2_ang_d;
  sps_pkg::res_t                res_q, res_d;
  sps_pkg::res_t                out_q, out_d;

  logic                         ram_we, ram_re;
  logic [PTR_W-1:0]             wslot;
  logic [CNT_W:0]               slot_sum;
  logic [sps_pkg::QENT_W-1:0]   ram_rdata;
  sps_pkg::qent_t               wr_ent;
  logic                         duty_req, duty_valid;
  logic [sps_pkg::DUTY_W-1:0]   duty;
  logic                         out_free;

  function automatic logic servo_ok(input logic [sps_pkg::SERVO_W-1:0] s);
    return (s != '0) && (32'(s) <= NUM_SERVOS);
  endfunction

  function automatic logic [sps_pkg::CHAN_W-1:0] chan_of(
      input logic [sps_pkg::SERVO_W-1:0] s);
    logic [sps_pkg::SERVO_W-1:0] t;
    t = s - sps_pkg::SERVO_W'(1);
    return t[sps_pkg::CHAN_W-1:0];
  endfunction

  // Tail slot of the command queue
  assign slot_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
  always_comb begin
    logic [CNT_W:0] wrapped;
    wrapped = (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
              (slot_sum - (CNT_W+1)'(QUEUE_DEPTH)) : slot_sum;
    wslot = wrapped[PTR_W-1:0];
  end

  assign wr_ent.servo   = item_i.servo;
  assign wr_ent.target  = item_i.ang;
  assign wr_ent.neutral = item_i.neu;

  assign idle_next = (idle_q == '1) ? idle_q : (idle_q + 1'b1);
  assign out_free  = !out_valid_q || out_ready_i;

  sps_ram #(
    .WIDTH (sps_pkg::QENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wslot),
    .wdata_i (wr_ent),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  sps_duty u_duty (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (duty_req),
    .ang_i   (op_ang_q),
    .lo_i    (cfg_i.min_pulse),
    .hi_i    (cfg_i.max_pulse),
    .valid_o (duty_valid),
    .duty_o  (duty)
  );

  // Next state, queue bookkeeping and result sequencing
  always_comb begin
    sps_pkg::qent_t             qent;
    logic [sps_pkg::CHAN_W-1:0] nxt;

    qent         = sps_pkg::qent_t'(ram_rdata);
    nxt          = pdn_cnt_q + 1'b1;
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    returning_d  = returning_q;
    countdown_d  = countdown_q;
    pend_servo_d = pend_servo_q;
    pend_neu_d   = pend_neu_q;
    idle_d       = idle_q;
    op2_pend_d   = op2_pend_q;
    pdn_d        = pdn_q;
    pdn_cnt_d    = pdn_cnt_q;
    op_chan_d    = op_chan_q;
    op_ang_d     = op_ang_q;
    op2_ang_d    = op2_ang_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    pop_o        = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    duty_req     = 1'b0;

    case (state_q)
      sps_pkg::ST_IDLE: begin
        ram_re = 1'b1;
        if (item_valid_i) begin
          pop_o = 1'b1;
          case (item_i.kind)
            sps_pkg::REQ_DIRECT: begin
              if (servo_ok(item_i.servo)) begin
                op_chan_d  = chan_of(item_i.servo);
                op_ang_d   = item_i.ang;
                op2_pend_d = 1'b0;
                idle_d     = '0;
                state_d    = sps_pkg::ST_DUTY;
              end
            end
            sps_pkg::REQ_QUEUE: begin
              if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                // Queue full: report the drop
                res_d.chan    = '0;
                res_d.duty    = '0;
                res_d.dropped = 1'b1;
                res_d.last    = 1'b1;
                pdn_d         = 1'b0;
                state_d       = sps_pkg::ST_EMIT;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            sps_pkg::REQ_TICK: begin
              idle_d = idle_next;
              if (returning_q) begin
                if (countdown_q > sps_pkg::RET_W'(1)) begin
                  countdown_d = countdown_q - 1'b1;
                end else begin
                  countdown_d = '0;
                  returning_d = 1'b0;
                  if (servo_ok(pend_servo_q)) begin
                    op_chan_d  = chan_of(pend_servo_q);
                    op_ang_d   = pend_neu_q;
                    op2_pend_d = 1'b0;
                    idle_d     = '0;
                    state_d    = sps_pkg::ST_DUTY;
                  end
                end
              end else if (count_q != '0) begin
                state_d = sps_pkg::ST_QTAKE;
              end else if (idle_next > cfg_i.idle_timeout) begin
                // Power down every channel
                idle_d        = '0;
                pdn_d         = 1'b1;
                pdn_cnt_d     = '0;
                res_d.chan    = '0;
                res_d.duty    = '0;
                res_d.dropped = 1'b0;
                res_d.last    = (LAST_CHAN == '0);
                state_d       = sps_pkg::ST_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      sps_pkg::ST_QTAKE: begin
        // Take the oldest quick action and start its hold when a return time is set
        head_d       = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : (head_q + 1'b1);
        count_d      = count_q - 1'b1;
        pend_servo_d = qent.servo;
        pend_neu_d   = qent.neutral;
        if (cfg_i.return_ms != '0) begin
          returning_d = 1'b1;
          countdown_d = cfg_i.return_ms;
        end
        if (servo_ok(qent.servo)) begin
          op_chan_d  = chan_of(qent.servo);
          op_ang_d   = qent.target;
          op2_ang_d  = qent.neutral;
          op2_pend_d = (cfg_i.return_ms == '0);
          idle_d     = '0;
          state_d    = sps_pkg::ST_DUTY;
        end else begin
          state_d = sps_pkg::ST_IDLE;
        end
      end

      sps_pkg::ST_DUTY: begin
        duty_req = 1'b1;
        state_d  = sps_pkg::ST_WAIT;
      end

      sps_pkg::ST_WAIT: begin
        if (duty_valid) begin
          res_d.chan    = op_chan_q;
          res_d.duty    = duty;
          res_d.dropped = 1'b0;
          res_d.last    = !op2_pend_q;
          state_d       = sps_pkg::ST_EMIT;
        end
      end

      sps_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          if (pdn_q && (pdn_cnt_q != LAST_CHAN)) begin
            pdn_cnt_d  = nxt;
            res_d.chan = nxt;
            res_d.last = (nxt == LAST_CHAN);
          end else if (op2_pend_q) begin
            op_ang_d   = op2_ang_q;
            op2_pend_d = 1'b0;
            state_d    = sps_pkg::ST_DUTY;
          end else begin
            pdn_d   = 1'b0;
            state_d = sps_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_d = sps_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sps_pkg::ST_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      returning_q  <= 1'b0;
      countdown_q  <= '0;
      pend_servo_q <= '0;
      pend_neu_q   <= sps_pkg::NEUTRAL_RST;
      idle_q       <= '0;
      op2_pend_q   <= 1'b0;
      pdn_q        <= 1'b0;
      pdn_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      returning_q  <= returning_d;
      countdown_q  <= countdown_d;
      pend_servo_q <= pend_servo_d;
      pend_neu_q   <= pend_neu_d;
      idle_q       <= idle_d;
      op2_pend_q   <= op2_pend_d;
      pdn_q        <= pdn_d;
      pdn_cnt_q    <= pdn_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    op_chan_q <= op_chan_d;
    op_ang_q  <= op_ang_d;
    op2_ang_q <= op2_ang_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign busy_o      = (state_q != sps_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[design/sps_front.sv]
module sps_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sps_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic [sps_pkg::TYPE_W-1:0]    in_type_i,
  input  logic                          pop_i,
  output logic                          item_valid_o,
  output sps_pkg::item_t                item_o
);

  sps_pkg::item_t ent;
  sps_pkg::item_t fifo_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           keep, push, pop;

  logic signed [sps_pkg::ANG_W-1:0] ang_raw, neu_raw;

  function automatic logic [sps_pkg::CANG_W-1:0] clamp(
      input logic signed [sps_pkg::ANG_W-1:0] a);
    logic [sps_pkg::CANG_W-1:0] r;
    if (a[sps_pkg::ANG_W-1]) begin
      r = '0;
    end else if (a[sps_pkg::ANG_W-2:0] > (sps_pkg::ANG_W-1)'(sps_pkg::ANGLE_MAX)) begin
      r = sps_pkg::ANGLE_MAX;
    end else begin
      r = a[sps_pkg::CANG_W-1:0];
    end
    return r;
  endfunction

  // Unpack and classify the request
  assign ang_raw = in_data_i[sps_pkg::SERVO_W +: sps_pkg::ANG_W];
  assign neu_raw = in_data_i[sps_pkg::SERVO_W + sps_pkg::ANG_W +: sps_pkg::ANG_W];

  always_comb begin
    ent.kind  = sps_pkg::req_e'(in_type_i);
    ent.servo = in_data_i[sps_pkg::SERVO_W-1:0];
    ent.ang   = clamp(ang_raw);
    ent.neu   = clamp(neu_raw);
    case (in_type_i)
      sps_pkg::REQ_DIRECT, sps_pkg::REQ_QUEUE, sps_pkg::REQ_TICK: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  // Drop unused request types at the door; queue the rest
  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o && keep;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = pop_i && item_valid_o;
  assign item_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= ent;
    end
  end

endmodule
